// ===== rtl/core/ptik_pkg.sv =====
// package for the pan/tilt inverse kinematics core
// widths, codes, item structs, arctangent table and the unwrap step; no dependencies
package ptik_pkg;

   // field widths
   localparam int POS_W      = 18;
   localparam int ANG_W      = 16;
   localparam int LEN_W      = 17;
   localparam int ERR_W      = 18;
   localparam int STATUS_W   = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;
   localparam int ERR_MAX    = (1 << ERR_W) - 1;

   // squares and square roots
   localparam int SQP_W      = 2 * POS_W;
   localparam int SQ_W       = SQP_W + 2;
   localparam int SQRT_RW    = SQ_W + 1;
   localparam int SQRT_STEPS = SQ_W / 2;
   localparam int SQRT_LAT   = SQRT_STEPS + 1;
   localparam int ROOT_W     = SQRT_STEPS + 1;
   localparam int MIN_HORIZONTAL = 246;

   // cordic
   localparam int CIN_W        = 20;
   localparam int SCALE_SHIFT  = 20;
   localparam int CW           = 44;
   localparam int ZW           = 27;
   localparam int CORDIC_STEPS = 16;
   localparam int CORDIC_LAT   = CORDIC_STEPS + 1;
   localparam int ATAN_LEN     = 24;
   localparam int ATAN_TABLE [0:ATAN_LEN-1] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0
   };
   localparam logic signed [ZW-1:0] HALF_TURN_Z = ZW'(180 * 65536);

   // angle unwrap and rounding, angles in 1/65536 degree
   localparam int AW           = 29;
   localparam int ANG_SCALE    = 9;
   localparam int RND_W        = AW - ANG_SCALE;
   localparam int UNWRAP_STEPS = 3;
   localparam logic signed [AW-1:0] HALF_TURN  = AW'(180 * 65536);
   localparam logic signed [AW-1:0] FULL_TURN  = AW'(360 * 65536);
   localparam logic signed [AW-1:0] ROUND_HALF = AW'(1 << (ANG_SCALE - 1));

   // input register, squares, sums, roots, cordic, unwrap head, unwrap steps, output
   localparam int PIPE_DEPTH = 3 + SQRT_LAT + CORDIC_LAT + 1 + UNWRAP_STEPS + 1;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 3'd0,
      ST_UNREACH    = 3'd1,
      ST_NEAR_VERT  = 3'd2,
      ST_PAN_LIMIT  = 3'd3,
      ST_TILT_LIMIT = 3'd4
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LINK_LENGTH = 3'd0,
      CSR_PAN_OFFSET  = 3'd1,
      CSR_TILT_OFFSET = 3'd2,
      CSR_PAN_MIN     = 3'd3,
      CSR_PAN_MAX     = 3'd4,
      CSR_TILT_MIN    = 3'd5,
      CSR_TILT_MAX    = 3'd6,
      CSR_REACH_TOL   = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] z;
      logic signed [ANG_W-1:0] prev_pan;
      logic signed [ANG_W-1:0] prev_tilt;
   } target_type;

   typedef struct packed {
      logic signed [ANG_W-1:0] prev_pan;
      logic signed [ANG_W-1:0] prev_tilt;
      status_type              status;
      logic [ERR_W-1:0]        err;
   } early_type;

   typedef struct packed {
      logic signed [AW-1:0]    pan;
      logic signed [AW-1:0]    pan_anchor;
      logic signed [AW-1:0]    tilt;
      logic signed [AW-1:0]    tilt_anchor;
      logic signed [ANG_W-1:0] prev_pan;
      logic signed [ANG_W-1:0] prev_tilt;
      status_type              status;
      logic [ERR_W-1:0]        err;
   } unwrap_type;

   // one turn toward the anchor when more than half a turn away
   function automatic logic signed [AW-1:0] unwrap_step(input logic signed [AW-1:0] angle,
                                                        input logic signed [AW-1:0] anchor);
      logic signed [AW-1:0] diff;
      diff = angle - anchor;
      if (diff > HALF_TURN) begin
         unwrap_step = angle - FULL_TURN;
      end else if (diff < -HALF_TURN) begin
         unwrap_step = angle + FULL_TURN;
      end else begin
         unwrap_step = angle;
      end
   endfunction

endpackage

// ===== rtl/core/pan_tilt_arm_inverse_kinematics_core.sv =====
// top level of the pan/tilt arm inverse kinematics core
// depends on ptik_pkg, ptik_sqrt and ptik_cordic
//
// One target item may be started in every clock cycle; busy never rises. Each item gives
// exactly one result, shown on the rsp_ ports for one cycle with rsp_valid high, in order.
// The receiver cannot stall: results must be taken as they come. The latency is set by
// the input, square and sum registers, the two 19-step square root pipelines (distance
// and horizontal radius, plus a rounding stage), the 16-iteration cordic pipelines that
// run after them, the offset stage, the three-step angle unwrap and the result register.
// Configuration writes take effect at once and should be made while no item is in flight.
module pan_tilt_arm_inverse_kinematics_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [ptik_pkg::POS_W-1:0]    req_target_x,
   input  logic signed [ptik_pkg::POS_W-1:0]    req_target_y,
   input  logic signed [ptik_pkg::POS_W-1:0]    req_target_z,
   input  logic signed [ptik_pkg::ANG_W-1:0]    req_prev_pan,
   input  logic signed [ptik_pkg::ANG_W-1:0]    req_prev_tilt,
   output logic                                 rsp_valid,
   output logic [ptik_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [ptik_pkg::ANG_W-1:0]    rsp_pan_angle,
   output logic signed [ptik_pkg::ANG_W-1:0]    rsp_tilt_angle,
   output logic [ptik_pkg::ERR_W-1:0]           rsp_reach_error,
   input  logic                                 csr_we,
   input  logic [ptik_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ptik_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import ptik_pkg::*;

   // configuration registers
   logic [LEN_W-1:0]        link_length_ff;
   logic signed [ANG_W-1:0] pan_offset_ff;
   logic signed [ANG_W-1:0] tilt_offset_ff;
   logic signed [ANG_W-1:0] pan_min_ff;
   logic signed [ANG_W-1:0] pan_max_ff;
   logic signed [ANG_W-1:0] tilt_min_ff;
   logic signed [ANG_W-1:0] tilt_max_ff;
   logic [LEN_W-1:0]        reach_tol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         link_length_ff <= LEN_W'(4293);
         pan_offset_ff  <= '0;
         tilt_offset_ff <= '0;
         pan_min_ff     <= ANG_W'(-23040);
         pan_max_ff     <= ANG_W'(23040);
         tilt_min_ff    <= ANG_W'(-23040);
         tilt_max_ff    <= ANG_W'(7680);
         reach_tol_ff   <= LEN_W'(164);
      end else if (csr_we) begin
         case (csr_index)
            CSR_LINK_LENGTH: link_length_ff <= csr_wdata[LEN_W-1:0];
            CSR_PAN_OFFSET:  pan_offset_ff  <= csr_wdata[ANG_W-1:0];
            CSR_TILT_OFFSET: tilt_offset_ff <= csr_wdata[ANG_W-1:0];
            CSR_PAN_MIN:     pan_min_ff     <= csr_wdata[ANG_W-1:0];
            CSR_PAN_MAX:     pan_max_ff     <= csr_wdata[ANG_W-1:0];
            CSR_TILT_MIN:    tilt_min_ff    <= csr_wdata[ANG_W-1:0];
            CSR_TILT_MAX:    tilt_max_ff    <= csr_wdata[ANG_W-1:0];
            CSR_REACH_TOL:   reach_tol_ff   <= csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // valid bits travel alongside the data
   logic [PIPE_DEPTH-1:0] vld_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[PIPE_DEPTH-2:0], start & ~busy};
      end
   end

   // input register, squares, sums
   target_type              in_ff;
   target_type              sq_side_ff;
   target_type              sum_side_ff;
   logic signed [SQP_W-1:0] xx_in;
   logic signed [SQP_W-1:0] yy_in;
   logic signed [SQP_W-1:0] zz_in;
   logic [SQP_W-1:0]        xx_ff;
   logic [SQP_W-1:0]        yy_ff;
   logic [SQP_W-1:0]        zz_ff;
   logic [SQ_W-1:0]         hsq_ff;
   logic [SQ_W-1:0]         rsq_ff;

   assign xx_in = in_ff.x * in_ff.x;
   assign yy_in = in_ff.y * in_ff.y;
   assign zz_in = in_ff.z * in_ff.z;

   always_ff @(posedge clock) begin
      in_ff       <= '{req_target_x, req_target_y, req_target_z, req_prev_pan, req_prev_tilt};
      xx_ff       <= $unsigned(xx_in);
      yy_ff       <= $unsigned(yy_in);
      zz_ff       <= $unsigned(zz_in);
      sq_side_ff  <= in_ff;
      hsq_ff      <= SQ_W'(xx_ff) + SQ_W'(yy_ff);
      rsq_ff      <= SQ_W'(xx_ff) + SQ_W'(yy_ff) + SQ_W'(zz_ff);
      sum_side_ff <= sq_side_ff;
   end

   // square roots of horizontal and full distance
   logic [ROOT_W-1:0] h_root;
   logic [ROOT_W-1:0] radius;
   target_type        root_side_ff [0:SQRT_LAT-1];
   target_type        root_side;

   ptik_sqrt u_sqrt_h (
      .clock    (clock),
      .radicand (hsq_ff),
      .root     (h_root)
   );

   ptik_sqrt u_sqrt_r (
      .clock    (clock),
      .radicand (rsq_ff),
      .root     (radius)
   );

   always_ff @(posedge clock) begin
      root_side_ff[0] <= sum_side_ff;
      for (int k = 1; k < SQRT_LAT; k++) begin
         root_side_ff[k] <= root_side_ff[k-1];
      end
   end

   assign root_side = root_side_ff[SQRT_LAT-1];

   // reach error and the early failure checks
   logic [ROOT_W-1:0] link_ext;
   logic [ROOT_W-1:0] err_full;
   logic [ERR_W-1:0]  err_sat;
   status_type        early_status;
   early_type         early_ff [0:CORDIC_LAT-1];
   early_type         early;

   assign link_ext = ROOT_W'(link_length_ff);
   assign err_full = (radius >= link_ext) ? radius - link_ext : link_ext - radius;
   assign err_sat  = (err_full > ROOT_W'(ERR_MAX)) ? ERR_W'(ERR_MAX) : err_full[ERR_W-1:0];

   always_comb begin
      if (radius == '0 || err_sat > ERR_W'(reach_tol_ff)) begin
         early_status = ST_UNREACH;
      end else if (h_root < ROOT_W'(MIN_HORIZONTAL)) begin
         early_status = ST_NEAR_VERT;
      end else begin
         early_status = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      early_ff[0] <= '{root_side.prev_pan, root_side.prev_tilt, early_status, err_sat};
      for (int k = 1; k < CORDIC_LAT; k++) begin
         early_ff[k] <= early_ff[k-1];
      end
   end

   assign early = early_ff[CORDIC_LAT-1];

   // pan = atan2(-y, x), tilt = atan2(z, h)
   logic signed [CIN_W-1:0] pan_px;
   logic signed [CIN_W-1:0] pan_py;
   logic signed [CIN_W-1:0] tilt_px;
   logic signed [CIN_W-1:0] tilt_py;
   logic signed [ZW-1:0]    pan_geom;
   logic signed [ZW-1:0]    tilt_geom;

   assign pan_px  = CIN_W'(root_side.x);
   assign pan_py  = -CIN_W'(root_side.y);
   assign tilt_px = $signed(h_root);
   assign tilt_py = CIN_W'(root_side.z);

   ptik_cordic u_cordic_pan (
      .clock (clock),
      .px    (pan_px),
      .py    (pan_py),
      .angle (pan_geom)
   );

   ptik_cordic u_cordic_tilt (
      .clock (clock),
      .px    (tilt_px),
      .py    (tilt_py),
      .angle (tilt_geom)
   );

   // offset removal and unwrap toward the previous angles
   unwrap_type uw_ff [0:UNWRAP_STEPS];

   always_ff @(posedge clock) begin
      uw_ff[0].pan         <= AW'(pan_geom) - (AW'(pan_offset_ff) <<< ANG_SCALE);
      uw_ff[0].pan_anchor  <= AW'(early.prev_pan) <<< ANG_SCALE;
      uw_ff[0].tilt        <= AW'(tilt_geom) - (AW'(tilt_offset_ff) <<< ANG_SCALE);
      uw_ff[0].tilt_anchor <= AW'(early.prev_tilt) <<< ANG_SCALE;
      uw_ff[0].prev_pan    <= early.prev_pan;
      uw_ff[0].prev_tilt   <= early.prev_tilt;
      uw_ff[0].status      <= early.status;
      uw_ff[0].err         <= early.err;
      for (int k = 0; k < UNWRAP_STEPS; k++) begin
         uw_ff[k+1].pan         <= unwrap_step(uw_ff[k].pan, uw_ff[k].pan_anchor);
         uw_ff[k+1].pan_anchor  <= uw_ff[k].pan_anchor;
         uw_ff[k+1].tilt        <= unwrap_step(uw_ff[k].tilt, uw_ff[k].tilt_anchor);
         uw_ff[k+1].tilt_anchor <= uw_ff[k].tilt_anchor;
         uw_ff[k+1].prev_pan    <= uw_ff[k].prev_pan;
         uw_ff[k+1].prev_tilt   <= uw_ff[k].prev_tilt;
         uw_ff[k+1].status      <= uw_ff[k].status;
         uw_ff[k+1].err         <= uw_ff[k].err;
      end
   end

   // round to 1/128 degree, limit checks, result register
   unwrap_type              uw_last;
   logic [AW-1:0]           pan_sum;
   logic [AW-1:0]           tilt_sum;
   logic signed [RND_W-1:0] pan_rnd;
   logic signed [RND_W-1:0] tilt_rnd;
   status_type              status_in;
   logic signed [ANG_W-1:0] pan_in;
   logic signed [ANG_W-1:0] tilt_in;
   status_type              status_ff;
   logic signed [ANG_W-1:0] pan_ff;
   logic signed [ANG_W-1:0] tilt_ff;
   logic [ERR_W-1:0]        err_ff;

   assign uw_last  = uw_ff[UNWRAP_STEPS];
   assign pan_sum  = uw_last.pan + ROUND_HALF;
   assign tilt_sum = uw_last.tilt + ROUND_HALF;
   assign pan_rnd  = pan_sum[AW-1:ANG_SCALE];
   assign tilt_rnd = tilt_sum[AW-1:ANG_SCALE];

   always_comb begin
      status_in = uw_last.status;
      pan_in    = uw_last.prev_pan;
      tilt_in   = uw_last.prev_tilt;
      if (uw_last.status == ST_OK) begin
         if (pan_rnd < RND_W'(pan_min_ff) || pan_rnd > RND_W'(pan_max_ff)) begin
            status_in = ST_PAN_LIMIT;
         end else if (tilt_rnd < RND_W'(tilt_min_ff) || tilt_rnd > RND_W'(tilt_max_ff)) begin
            status_in = ST_TILT_LIMIT;
         end else begin
            pan_in  = pan_rnd[ANG_W-1:0];
            tilt_in = tilt_rnd[ANG_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      pan_ff    <= pan_in;
      tilt_ff   <= tilt_in;
      err_ff    <= uw_last.err;
   end

   assign rsp_valid       = vld_ff[PIPE_DEPTH-1];
   assign rsp_status      = status_ff;
   assign rsp_pan_angle   = pan_ff;
   assign rsp_tilt_angle  = tilt_ff;
   assign rsp_reach_error = err_ff;

endmodule

// ===== rtl/core/ptik_sqrt.sv =====
// pipelined integer square root, one result bit per stage, rounded to nearest
// depends on ptik_pkg
module ptik_sqrt (
   input  logic                          clock,
   input  logic [ptik_pkg::SQ_W-1:0]     radicand,
   output logic [ptik_pkg::ROOT_W-1:0]   root
);
   import ptik_pkg::*;

   logic [SQRT_RW-1:0] rem_src [0:SQRT_STEPS-1];
   logic [SQRT_RW-1:0] r_src   [0:SQRT_STEPS-1];
   logic [SQRT_RW-1:0] rem_in  [0:SQRT_STEPS-1];
   logic [SQRT_RW-1:0] r_in    [0:SQRT_STEPS-1];
   logic [SQRT_RW-1:0] rem_ff  [0:SQRT_STEPS-1];
   logic [SQRT_RW-1:0] r_ff    [0:SQRT_STEPS-1];
   logic [ROOT_W-1:0]  root_ff;

   always_comb begin
      rem_src[0] = SQRT_RW'(radicand);
      r_src[0]   = '0;
      for (int k = 1; k < SQRT_STEPS; k++) begin
         rem_src[k] = rem_ff[k-1];
         r_src[k]   = r_ff[k-1];
      end
   end

   always_comb begin
      for (int k = 0; k < SQRT_STEPS; k++) begin
         if (rem_src[k] >= r_src[k] + (SQRT_RW'(1) << (2 * (SQRT_STEPS - 1 - k)))) begin
            rem_in[k] = rem_src[k] - r_src[k] - (SQRT_RW'(1) << (2 * (SQRT_STEPS - 1 - k)));
            r_in[k]   = (r_src[k] >> 1) + (SQRT_RW'(1) << (2 * (SQRT_STEPS - 1 - k)));
         end else begin
            rem_in[k] = rem_src[k];
            r_in[k]   = r_src[k] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < SQRT_STEPS; k++) begin
         rem_ff[k] <= rem_in[k];
         r_ff[k]   <= r_in[k];
      end
      // round up when the remainder exceeds the root
      if (rem_ff[SQRT_STEPS-1] > r_ff[SQRT_STEPS-1]) begin
         root_ff <= ROOT_W'(r_ff[SQRT_STEPS-1] + SQRT_RW'(1));
      end else begin
         root_ff <= ROOT_W'(r_ff[SQRT_STEPS-1]);
      end
   end

   assign root = root_ff;

endmodule

// ===== rtl/core/ptik_cordic.sv =====
// pipelined vectoring cordic: atan2(py, px) in 1/65536 degree, one iteration per stage
// depends on ptik_pkg
module ptik_cordic (
   input  logic                               clock,
   input  logic signed [ptik_pkg::CIN_W-1:0]  px,
   input  logic signed [ptik_pkg::CIN_W-1:0]  py,
   output logic signed [ptik_pkg::ZW-1:0]     angle
);
   import ptik_pkg::*;

   logic signed [CW-1:0] x_scaled;
   logic signed [CW-1:0] y_scaled;
   logic signed [CW-1:0] x_ff [0:CORDIC_STEPS-1];
   logic signed [CW-1:0] y_ff [0:CORDIC_STEPS-1];
   logic signed [ZW-1:0] z_ff [0:CORDIC_STEPS];
   logic signed [CW-1:0] x_in [0:CORDIC_STEPS-1];
   logic signed [CW-1:0] y_in [0:CORDIC_STEPS-1];
   logic signed [ZW-1:0] z_in [0:CORDIC_STEPS];

   assign x_scaled = CW'(px) <<< SCALE_SHIFT;
   assign y_scaled = CW'(py) <<< SCALE_SHIFT;

   // left half plane: turn by half a turn first
   always_comb begin
      if (px < 0) begin
         x_in[0] = -x_scaled;
         y_in[0] = -y_scaled;
         z_in[0] = (py >= 0) ? HALF_TURN_Z : -HALF_TURN_Z;
      end else begin
         x_in[0] = x_scaled;
         y_in[0] = y_scaled;
         z_in[0] = '0;
      end
   end

   always_comb begin
      for (int k = 0; k < CORDIC_STEPS; k++) begin
         if (!y_ff[k][CW-1]) begin
            z_in[k+1] = z_ff[k] + ZW'(ATAN_TABLE[k]);
         end else begin
            z_in[k+1] = z_ff[k] - ZW'(ATAN_TABLE[k]);
         end
      end
      for (int k = 0; k < CORDIC_STEPS - 1; k++) begin
         if (!y_ff[k][CW-1]) begin
            x_in[k+1] = x_ff[k] + (y_ff[k] >>> k);
            y_in[k+1] = y_ff[k] - (x_ff[k] >>> k);
         end else begin
            x_in[k+1] = x_ff[k] - (y_ff[k] >>> k);
            y_in[k+1] = y_ff[k] + (x_ff[k] >>> k);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < CORDIC_STEPS; k++) begin
         x_ff[k] <= x_in[k];
         y_ff[k] <= y_in[k];
      end
      for (int k = 0; k <= CORDIC_STEPS; k++) begin
         z_ff[k] <= z_in[k];
      end
   end

   assign angle = z_ff[CORDIC_STEPS];

endmodule

// ===== rtl/core/ptik_checker.sv =====
// port-level checks for the pan/tilt inverse kinematics core, bound to the top level
// depends on ptik_pkg and pan_tilt_arm_inverse_kinematics_core
module ptik_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 start,
   input logic                                 busy,
   input logic signed [ptik_pkg::ANG_W-1:0]    req_prev_pan,
   input logic signed [ptik_pkg::ANG_W-1:0]    req_prev_tilt,
   input logic                                 rsp_valid,
   input logic [ptik_pkg::STATUS_W-1:0]        rsp_status,
   input logic signed [ptik_pkg::ANG_W-1:0]    rsp_pan_angle,
   input logic signed [ptik_pkg::ANG_W-1:0]    rsp_tilt_angle
);
   import ptik_pkg::*;

   // the core never pushes back
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   // every result comes from an item taken a fixed latency earlier
   a_result_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, PIPE_DEPTH))
      else $error("result without a matching item");

   // failures echo the previous angles of the same item
   a_fail_echo_pan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_pan_angle == $past(req_prev_pan, PIPE_DEPTH))
      else $error("pan not echoed on failure");

   a_fail_echo_tilt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_tilt_angle == $past(req_prev_tilt, PIPE_DEPTH))
      else $error("tilt not echoed on failure");

endmodule

bind pan_tilt_arm_inverse_kinematics_core ptik_checker u_ptik_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_prev_pan   (req_prev_pan),
   .req_prev_tilt  (req_prev_tilt),
   .rsp_valid      (rsp_valid),
   .rsp_status     (rsp_status),
   .rsp_pan_angle  (rsp_pan_angle),
   .rsp_tilt_angle (rsp_tilt_angle)
);
